@@ sv/assert_macros.svh @@
// Assertion macros shared by the blit queue and back part.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/sbck_pkg.sv @@
// Package with shared constants and types of the scaled blit.
package sbck_pkg;
  localparam int MAX_SIDE_DEF = 1024;
  localparam int ADDR_BITS_DEF = 20;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int OUT_ADDR_BITS = 20;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_WIDTH = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_WIDTH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DST_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPAN_W = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPAN_H = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_KEY = 3'd7;

  typedef struct packed {
    logic [7:0] pix;
    logic       first;
  } in_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       first;
    logic       we;
  } cmd_t;

  typedef struct packed {
    logic [OUT_ADDR_BITS-1:0] dst_address;
    logic                     write_enable;
    logic [7:0]               write_data;
    logic [OUT_ADDR_BITS-1:0] next_src_address;
    logic                     last;
  } res_t;
endpackage

@@ sv/sbck_if.sv @@
// Valid/ready channel interface carrying one payload.
interface sbck_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/sbck_front.sv @@
// Front part: accepts requests, drops idle ones and applies the color key.
module sbck_front import sbck_pkg::*; (
  input  logic [7:0] in_pix,
  input  logic       in_first,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] key,
  input  logic       busy,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);
  assign in_ready = !q_full;
  assign q_push = in_valid && !q_full && (in_first || busy);
  always_comb begin
    q_cmd.pix = in_pix;
    q_cmd.first = in_first;
    q_cmd.we = !(key[8] && in_pix == key[7:0]);
  end
endmodule

@@ sv/sbck_queue.sv @@
// Two-entry queue between the front and back parts.
module sbck_queue import sbck_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic pending,
  input  logic pop,
  output logic empty,
  output cmd_t head
);
  `include "assert_macros.svh"
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign pending = !empty;
  assign head = mem_r[rp_r];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end
  `ASSERT_IMPL(a_no_overflow, clk, rst_n, full, !push)
  `ASSERT_IMPL(a_no_underflow, clk, rst_n, empty, !pop)
endmodule

@@ sv/sbck_back.sv @@
// Back part: Bresenham address stepping with iterative source skips.
module sbck_back import sbck_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [10:0] src_width,
  input  logic [10:0] src_height,
  input  logic [10:0] dst_width,
  input  logic [9:0]  dst_x,
  input  logic [9:0]  dst_y,
  input  logic [11:0] span_w,
  input  logic [11:0] span_h,
  input  logic        q_empty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);
  `include "assert_macros.svh"
  localparam int EB = 14;
  localparam int AW = ADDR_BITS;
  typedef enum logic [2:0] {S_IDLE, S_HSKIP, S_VSKIP, S_DONE} st_t;
  st_t st_r;
  logic [AW-1:0] row_base_r, offset_r, drow_r, cur_r, addr_r;
  logic signed [EB-1:0] herr_r, verr_r;
  logic [11:0] cols_r, rows_r;
  logic [7:0] pix_r;
  logic we_r, last_r;
  logic ov_r;
  logic ov_set;
  res_t res_r;

  function automatic logic [11:0] magf(input logic [11:0] s);
    logic [11:0] m;
    m = s[11] ? (~s + 12'd1) : s;
    if (s == 12'h800) m = 12'd2048;
    if (int'(m) > MAX_SIDE) m = 12'(MAX_SIDE);
    return m;
  endfunction

  logic [11:0] dx, dy, dxs, dys;
  logic signed [EB-1:0] du2, dv2, dx2, dy2;
  logic [AW-1:0] row0, col0, start;
  always_comb begin
    dx = magf(span_w);
    dy = magf(span_h);
    dxs = (dx == 12'd0) ? 12'd1 : dx;
    dys = (dy == 12'd0) ? 12'd1 : dy;
    du2 = EB'({src_width, 1'b0});
    dv2 = EB'({src_height, 1'b0});
    dx2 = EB'({dxs, 1'b0});
    dy2 = EB'({dys, 1'b0});
    row0 = (!span_h[11]) ? AW'(dst_y) : AW'({2'b0, dst_y} + dy - 12'd1);
    col0 = (!span_w[11]) ? AW'(dst_x) : AW'({2'b0, dst_x} + dx - 12'd1);
    start = AW'(row0 * AW'(dst_width) + col0);
  end

  assign busy = rows_r != 12'd0;
  assign q_pop = (st_r == S_IDLE) && !q_empty && (!ov_r || out_ready);
  assign ov_set = (st_r == S_DONE) || (q_pop && q_head.first && (dx == 12'd0 || dy == 12'd0));
  assign out_valid = ov_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; rows_r <= '0; cols_r <= '0;
      row_base_r <= '0; offset_r <= '0; herr_r <= '0; verr_r <= '0;
      drow_r <= '0; cur_r <= '0;
    end else begin
      if (ov_set) ov_r <= 1'b1;
      else if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            pix_r <= q_head.pix;
            if (q_head.first && (dx == 12'd0 || dy == 12'd0)) begin
              rows_r <= '0; cols_r <= '0;
              res_r <= '{dst_address: '0, write_enable: 1'b0, write_data: '0,
                         next_src_address: '0, last: 1'b1};
            end else if (q_head.first) begin
              row_base_r <= '0; offset_r <= '0;
              herr_r <= du2 - EB'(dx); verr_r <= dv2 - EB'(dy);
              drow_r <= start; cur_r <= start; addr_r <= start;
              cols_r <= dx; rows_r <= dy;
              we_r <= q_head.we;
              st_r <= S_HSKIP;
            end else if (rows_r != 12'd0) begin
              addr_r <= cur_r;
              we_r <= q_head.we;
              st_r <= S_HSKIP;
            end
          end
        end
        S_HSKIP: begin
          if (!herr_r[EB-1]) begin
            offset_r <= offset_r + AW'(1);
            herr_r <= herr_r - dx2;
          end else begin
            herr_r <= herr_r + du2;
            cur_r <= span_w[11] ? cur_r - AW'(1) : cur_r + AW'(1);
            if (cols_r <= 12'd1) begin
              cols_r <= '0;
              st_r <= S_VSKIP;
            end else begin
              cols_r <= cols_r - 12'd1;
              last_r <= 1'b0;
              st_r <= S_DONE;
            end
          end
        end
        S_VSKIP: begin
          if (!verr_r[EB-1]) begin
            row_base_r <= row_base_r + AW'(src_width);
            verr_r <= verr_r - dy2;
          end else begin
            verr_r <= verr_r + dv2;
            drow_r <= span_h[11] ? drow_r - AW'(dst_width) : drow_r + AW'(dst_width);
            if (rows_r <= 12'd1) begin
              rows_r <= '0;
              last_r <= 1'b1;
            end else begin
              rows_r <= rows_r - 12'd1;
              cols_r <= dxs;
              offset_r <= '0;
              herr_r <= du2 - EB'(dxs);
              cur_r <= span_h[11] ? drow_r - AW'(dst_width) : drow_r + AW'(dst_width);
              last_r <= 1'b0;
            end
            st_r <= S_DONE;
          end
        end
        S_DONE: begin
          res_r.dst_address <= OUT_ADDR_BITS'(addr_r);
          res_r.write_enable <= we_r;
          res_r.write_data <= pix_r;
          res_r.next_src_address <= last_r ? '0 : OUT_ADDR_BITS'(row_base_r + offset_r);
          res_r.last <= last_r;
          if (last_r) begin
            row_base_r <= '0; offset_r <= '0;
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_one_at_a_time, clk, rst_n, st_r != S_IDLE, !q_pop)
  `ASSERT_NEXT(a_done_shows, clk, rst_n, st_r == S_DONE, ov_r)
endmodule

@@ sv/scaled_blit_color_key_top.sv @@
// Top level of the scaled blit address and write generator.
// The input channel carries a source pixel and a first flag per request;
// first starts a new blit whose first pixel sits at source address zero.
// Each later request must carry the pixel at the previous result's
// next_src_address. A request with first low while no blit runs is dropped.
// Each taken request gives one result: destination address, write enable,
// data, next source address and a last mark. A zero span gives one
// non-writing last result. Otherwise the back part stays in its
// horizontal skip state while source columns are skipped; at a row end
// it also passes the vertical skip state while source rows are skipped,
// then registers the result. The back part takes no new request until
// it is through with the last one and back in idle.
// A two-entry queue lets the front take requests while the back works.
// Configuration is written through cfg_we, cfg_index and cfg_data.
// Reset is synchronous and returns the block to idle with empty queue.
// When the receiver stalls, the result is held and the queue fills up.
module scaled_blit_color_key_top import sbck_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  sbck_if.sink                     in_ch,
  sbck_if.source                   out_ch
);
  logic [10:0] src_width_r, src_height_r, dst_width_r;
  logic [9:0] dst_x_r, dst_y_r;
  logic [11:0] span_w_r, span_h_r;
  logic [8:0] key_r;
  logic busy, q_full, q_push, q_pop, q_empty, q_pending;
  cmd_t q_cmd, q_head;
  res_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r <= 11'd1; src_height_r <= 11'd1; dst_width_r <= 11'd1;
      dst_x_r <= '0; dst_y_r <= '0; span_w_r <= '0; span_h_r <= '0; key_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH: src_width_r <= cfg_data[10:0];
        REG_SRC_HEIGHT: src_height_r <= cfg_data[10:0];
        REG_DST_WIDTH: dst_width_r <= cfg_data[10:0];
        REG_DST_X: dst_x_r <= cfg_data[9:0];
        REG_DST_Y: dst_y_r <= cfg_data[9:0];
        REG_SPAN_W: span_w_r <= cfg_data;
        REG_SPAN_H: span_h_r <= cfg_data;
        REG_KEY: key_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  sbck_front u_front (
    .in_pix(in_ch.data[8:1]), .in_first(in_ch.data[0]),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .key(key_r), .busy(busy || q_pending), .q_full(q_full),
    .q_push(q_push), .q_cmd(q_cmd)
  );

  sbck_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(q_cmd), .full(q_full),
    .pending(q_pending), .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  sbck_back #(.MAX_SIDE(MAX_SIDE), .ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .src_width(src_width_r), .src_height(src_height_r), .dst_width(dst_width_r),
    .dst_x(dst_x_r), .dst_y(dst_y_r), .span_w(span_w_r), .span_h(span_h_r),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop), .busy(busy),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.data = res;
endmodule
